/* rtl/sorted_list_insert_remove_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sorted list insert/remove unit - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_UNIT_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_UNIT_MACROS_SVH

// Same-cycle implication
`define SLRI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SLRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/slri_pkg.sv */
// ----------------------------------------------------------------------------
// slri_pkg
// Types and codes shared by the sorted list cells, top level and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package slri_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Operation codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    // Control broadcast to every cell
    typedef struct packed {
        logic               cmp;    // latch compare flags
        logic               upd;    // commit shift / write
        t_op                op;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/slri_cell.sv */
// ----------------------------------------------------------------------------
// slri_cell
// One slot of the sorted list: holds a value, compares it against the
// broadcast operand, and shifts with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module slri_cell (
    input  wire logic                 i_clk,
    input  wire slri_pkg::t_cell_ctl  i_ctl,
    input  wire logic                 i_occ,        // slot holds a live value
    input  wire logic                 i_left_lt,    // left slot sorts before operand
    input  wire logic signed [31:0]   i_left_val,
    input  wire logic signed [31:0]   i_right_val,
    output logic signed [31:0]        o_val,
    output logic                      o_lt,
    output logic                      o_hit
);

    logic signed [31:0] r_val;
    logic               r_lt;
    logic               r_eq;
    logic signed [31:0] n_val;
    logic               boundary;

    // First slot not below the operand
    assign boundary = !r_lt && i_left_lt;

    // Insert writes at the boundary and shifts right; remove shifts left
    always_comb begin
        case (i_ctl.op)
            slri_pkg::OP_INSERT: n_val = boundary ? i_ctl.value : i_left_val;
            slri_pkg::OP_REMOVE: n_val = i_right_val;
            default:             n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_occ && (r_val < i_ctl.value);
            r_eq <= (r_val == i_ctl.value);
        end
        if (i_ctl.upd && !r_lt) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_hit = boundary && i_occ && r_eq;

endmodule

`default_nettype wire

/* rtl/sorted_list_insert_remove_unit.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit
// Ascending table of signed values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Each input transaction passes through the sequencer states in order: the
// operand is captured on acceptance, every cell compares it against its value
// in parallel in S_CMP, then in S_UPD all cells shift or write in one step and
// the count updates; the result register loads in S_LOAD, when the next
// transaction may already be accepted. S_LOAD waits for the result register
// to be free, so a stalled result holds up the next input transaction. A new
// transaction is not taken until the previous one reaches the result load.
// Inserts keep duplicates (a new copy goes ahead of older ones); removes
// delete the first copy. Insert into a full table or remove from an empty
// table or of a missing value leaves the table unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_opcode,
    input  wire logic signed [31:0] i_value,
    // output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_status,
    output logic [4:0]              o_count,
    output logic signed [31:0]      o_smallest,
    output logic signed [31:0]      o_largest
);

    localparam int CW = $clog2(DEPTH + 1);

    slri_pkg::t_state    r_state, n_state;
    slri_pkg::t_op       r_op;
    logic signed [31:0]  r_item_val;
    logic [CW-1:0]       r_count;
    slri_pkg::t_status   r_status;
    logic                r_out_vld;
    logic [1:0]          r_out_status;
    logic [4:0]          r_out_count;
    logic signed [31:0]  r_out_small;
    logic signed [31:0]  r_out_large;

    slri_pkg::t_cell_ctl cell_ctl;
    logic signed [31:0]  cell_val [DEPTH];
    logic [DEPTH-1:0]    cell_lt;
    logic [DEPTH-1:0]    cell_hit;
    logic [DEPTH-1:0]    cell_occ;
    logic [DEPTH-1:0]    cell_last;

    logic                in_acc;
    logic                out_free;
    logic                load;
    logic                found;
    logic                is_full;
    logic                is_empty;
    logic                commit;
    slri_pkg::t_status   n_status;
    logic signed [31:0]  last_val;

    // Handshake
    assign out_free = !r_out_vld || !i_stall;
    assign load     = (r_state == slri_pkg::S_LOAD) && out_free;
    assign o_stall  = !((r_state == slri_pkg::S_IDLE) || load);
    assign in_acc   = i_valid && !o_stall;

    // Table status for the update step
    assign found    = |cell_hit;
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        commit   = 1'b0;
        n_status = slri_pkg::ST_DONE;
        case (r_op)
            slri_pkg::OP_INSERT: begin
                if (is_full) n_status = slri_pkg::ST_FULL;
                else         commit   = 1'b1;
            end
            slri_pkg::OP_REMOVE: begin
                if (is_empty)    n_status = slri_pkg::ST_EMPTY;
                else if (!found) n_status = slri_pkg::ST_NOT_FOUND;
                else             commit   = 1'b1;
            end
            default: n_status = slri_pkg::ST_DONE;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            slri_pkg::S_IDLE: if (in_acc) n_state = slri_pkg::S_CMP;
            slri_pkg::S_CMP:  n_state = slri_pkg::S_UPD;
            slri_pkg::S_UPD:  n_state = slri_pkg::S_LOAD;
            slri_pkg::S_LOAD: begin
                if (out_free) n_state = in_acc ? slri_pkg::S_CMP : slri_pkg::S_IDLE;
            end
            default: n_state = slri_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slri_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == slri_pkg::S_UPD) && commit) begin
                r_count <= (r_op == slri_pkg::OP_INSERT) ? r_count + 1'b1
                                                         : r_count - 1'b1;
            end
        end
    end

    // Operand capture and status
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= slri_pkg::t_op'(i_opcode);
            r_item_val <= i_value;
        end
        if (r_state == slri_pkg::S_UPD) begin
            r_status <= n_status;
        end
    end

    // Cell chain
    assign cell_ctl.cmp   = (r_state == slri_pkg::S_CMP);
    assign cell_ctl.upd   = (r_state == slri_pkg::S_UPD) && commit;
    assign cell_ctl.op    = r_op;
    assign cell_ctl.value = r_item_val;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        assign cell_occ[k]  = (CW'(k) < r_count);
        assign cell_last[k] = (r_count == CW'(k + 1));

        slri_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_occ       (cell_occ[k]),
            .i_left_lt   ((k == 0) ? 1'b1 : cell_lt[(k == 0) ? 0 : k - 1]),
            .i_left_val  (cell_val[(k == 0) ? 0 : k - 1]),
            .i_right_val (cell_val[(k == DEPTH - 1) ? k : k + 1]),
            .o_val       (cell_val[k]),
            .o_lt        (cell_lt[k]),
            .o_hit       (cell_hit[k])
        );
    end

    // Last live value, zero when empty
    always_comb begin
        last_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            last_val = last_val | (cell_val[k] & {32{cell_last[k]}});
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= r_status;
            r_out_count  <= 5'(r_count);
            r_out_small  <= is_empty ? '0 : cell_val[0];
            r_out_large  <= last_val;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_status   = r_out_status;
    assign o_count    = r_out_count;
    assign o_smallest = r_out_small;
    assign o_largest  = r_out_large;

endmodule

`default_nettype wire

/* rtl/slri_checker.sv */
// ----------------------------------------------------------------------------
// slri_checker
// Port-level checks on the sorted list unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_remove_unit_macros.svh"

module slri_checker #(
    parameter int DEPTH = 16
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [1:0]         o_status,
    input wire logic [4:0]         o_count,
    input wire logic signed [31:0] o_smallest,
    input wire logic signed [31:0] o_largest
);

    // A stalled result transaction holds
    `SLRI_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_count) && $stable(o_status) && $stable(o_smallest) && $stable(o_largest), "stalled result changed")

    // Full status only with a full table
    `SLRI_ASSERT_SAME(a_full_count, o_valid && (o_status == slri_pkg::ST_FULL), o_count == 5'(DEPTH), "full status with table not full")

    // Empty status reports an empty table with zero extremes
    `SLRI_ASSERT_SAME(a_empty_zero, o_valid && (o_status == slri_pkg::ST_EMPTY), (o_count == 5'd0) && (o_smallest == 32'sd0) && (o_largest == 32'sd0), "empty status with nonzero result")

    // Table stays ordered
    `SLRI_ASSERT_SAME(a_ordered, o_valid && (o_count != 5'd0), o_smallest <= o_largest, "smallest above largest")

endmodule

bind sorted_list_insert_remove_unit slri_checker #(
    .DEPTH (DEPTH)
) u_slri_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_status   (o_status),
    .o_count    (o_count),
    .o_smallest (o_smallest),
    .o_largest  (o_largest)
);

`default_nettype wire

/* dv/sorted_list_insert_remove_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit_checker
// Watches both channels of the sorted list unit and predicts each result from
// a private ascending table. Every returned transaction is compared field by
// field against the oldest prediction. The checker reports a running error
// count and the number of results still owed.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_unit_checker #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel of the block
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_in_opcode,
    input  logic signed [31:0] i_in_value,
    // output channel of the block
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_out_status,
    input  logic [4:0]         i_out_count,
    input  logic signed [31:0] i_out_smallest,
    input  logic signed [31:0] i_out_largest,
    // summary for the testbench top
    output int                 o_error_count,
    output int                 o_outstanding,
    output int                 o_checked
);

    typedef struct packed {
        slri_pkg::t_status  status;
        logic [4:0]         count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
    } t_list_result;

    // Predicted table contents, ascending in positions below held
    logic signed [31:0] sorted_vals [DEPTH];
    int                 held;
    t_list_result       owed_results[$];
    int                 errors;
    int                 checked;

    initial begin
        held          = 0;
        errors        = 0;
        checked       = 0;
        o_error_count = 0;
        o_outstanding = 0;
        o_checked     = 0;
    end

    // Apply one transaction to the predicted table and form its result
    function automatic t_list_result apply_list_op(input slri_pkg::t_op op,
                                                   input logic signed [31:0] v);
        t_list_result r;
        int           pos;
        int           k;
        pos = 0;
        if (op == slri_pkg::OP_INSERT) begin
            if (held >= DEPTH) begin
                r.status = slri_pkg::ST_FULL;
            end else begin
                // new copy goes ahead of any equal values
                while (pos < held && sorted_vals[pos] < v) pos++;
                for (k = held; k > pos; k--) sorted_vals[k] = sorted_vals[k - 1];
                sorted_vals[pos] = v;
                held++;
                r.status = slri_pkg::ST_DONE;
            end
        end else if (held == 0) begin
            r.status = slri_pkg::ST_EMPTY;
        end else begin
            while (pos < held && sorted_vals[pos] != v) pos++;
            if (pos >= held) begin
                r.status = slri_pkg::ST_NOT_FOUND;
            end else begin
                for (k = pos; k + 1 < held; k++) sorted_vals[k] = sorted_vals[k + 1];
                held--;
                r.status = slri_pkg::ST_DONE;
            end
        end
        r.count = held[4:0];
        if (held == 0) begin
            r.smallest = '0;
            r.largest  = '0;
        end else begin
            r.smallest = sorted_vals[0];
            r.largest  = sorted_vals[held - 1];
        end
        return r;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            held = 0;
            owed_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(
                    apply_list_op(slri_pkg::t_op'(i_in_opcode), i_in_value));
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with none expected: status %0d count %0d",
                           i_out_status, i_out_count);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (i_out_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_out_status);
                        errors++;
                    end
                    if (i_out_count !== want.count) begin
                        $error("count mismatch: expected %0d, actual %0d",
                               want.count, i_out_count);
                        errors++;
                    end
                    if (i_out_smallest !== want.smallest) begin
                        $error("smallest mismatch: expected %0d, actual %0d",
                               want.smallest, i_out_smallest);
                        errors++;
                    end
                    if (i_out_largest !== want.largest) begin
                        $error("largest mismatch: expected %0d, actual %0d",
                               want.largest, i_out_largest);
                        errors++;
                    end
                end
            end
        end
        o_outstanding <= owed_results.size();
        o_error_count <= errors;
        o_checked     <= checked;
    end

endmodule

/* dv/tb_sorted_list_insert_remove_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_remove_unit
// Drives insert and remove transactions into the sorted list unit: a short
// directed pass over empty, full, duplicate and extreme-value cases, then
// random phases biased to fill, drain or hover the table. Both sides idle
// in random bursts; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_remove_unit;

    localparam int                 DEPTH          = 16;
    localparam int                 SEGMENTS       = 39;
    localparam int                 SEG_LEN        = 50;
    localparam int                 QUIET_SEGMENTS = 3;
    localparam int                 RECENT_MAX     = 24;
    localparam logic signed [31:0] MIN_VAL        = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_VAL        = 32'sh7FFF_FFFF;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               i_opcode   = 1'b0;
    logic signed [31:0] i_value    = '0;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [4:0]         o_count;
    logic signed [31:0] o_smallest;
    logic signed [31:0] o_largest;

    int                 error_count;
    int                 outstanding;
    int                 checked;
    int                 n_inserts  = 0;
    int                 n_removes  = 0;
    int                 gap_odds   = 0;
    int                 stall_odds = 0;
    int                 stall_left = 0;
    int                 stall_run  = 0;
    logic               quiet_tail = 1'b0;
    logic signed [31:0] recent_vals[$];

    sorted_list_insert_remove_unit #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_count    (o_count),
        .o_smallest (o_smallest),
        .o_largest  (o_largest)
    );

    sorted_list_insert_remove_unit_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_opcode    (i_opcode),
        .i_in_value     (i_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_out_status   (o_status),
        .i_out_count    (o_count),
        .i_out_smallest (o_smallest),
        .i_out_largest  (o_largest),
        .o_error_count  (error_count),
        .o_outstanding  (outstanding),
        .o_checked      (checked)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle density for a stretch: none, light or heavy
    function automatic int pick_idle_odds();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 2;
            default: return 5;
        endcase
    endfunction

    // Operand choice: small pool for duplicates and hits, extremes, full range,
    // and for removes in part values inserted not long ago
    function automatic logic signed [31:0] pick_value(input logic for_remove);
        int sel;
        sel = $urandom_range(0, 9);
        if (for_remove && recent_vals.size() > 0 && sel < 4)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        if (sel < 7)
            return int'($urandom_range(0, 15)) - 8;
        if (sel == 7 || (for_remove && sel == 8)) begin
            case ($urandom_range(0, 3))
                0: return MIN_VAL;
                1: return MAX_VAL;
                2: return MIN_VAL + 1;
                default: return MAX_VAL - 1;
            endcase
        end
        return $urandom;
    endfunction

    // Receiver stall bursts at a density redrawn by pick_idle_odds
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet_tail) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_odds = pick_idle_odds();
                stall_run  = 150;
            end
            stall_run--;
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (stall_odds != 0 && $urandom_range(0, 9) < stall_odds) begin
                stall_left = $urandom_range(0, 6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // One input transaction, optionally preceded by an idle burst
    task automatic send_item(input slri_pkg::t_op op, input logic signed [31:0] v);
        int gap;
        @(negedge i_clk);
        if (gap_odds != 0 && $urandom_range(0, 9) < gap_odds) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (op == slri_pkg::OP_INSERT) begin
            n_inserts++;
            recent_vals.push_back(v);
            if (recent_vals.size() > RECENT_MAX) void'(recent_vals.pop_front());
        end else begin
            n_removes++;
        end
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Stimulus and verdict
    initial begin
        int seg;
        int n;
        int insert_pct;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty remove, extremes, duplicates, missing value, full table
        send_item(slri_pkg::OP_REMOVE, 32'sd5);
        send_item(slri_pkg::OP_INSERT, 32'sd0);
        send_item(slri_pkg::OP_INSERT, MAX_VAL);
        send_item(slri_pkg::OP_INSERT, MIN_VAL);
        send_item(slri_pkg::OP_INSERT, -32'sd1);
        send_item(slri_pkg::OP_INSERT, 32'sd0);
        send_item(slri_pkg::OP_REMOVE, 32'sd7);
        send_item(slri_pkg::OP_REMOVE, 32'sd0);
        for (n = 0; n < DEPTH - 4; n++) send_item(slri_pkg::OP_INSERT, n * 3 - 17);
        send_item(slri_pkg::OP_INSERT, 32'sd1);
        send_item(slri_pkg::OP_REMOVE, MIN_VAL);
        send_item(slri_pkg::OP_REMOVE, MAX_VAL);
        send_item(slri_pkg::OP_REMOVE, -32'sd1);
        wait_drained();

        // random phases biased to fill, drain or hover
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS - QUIET_SEGMENTS) quiet_tail <= 1'b1;
            gap_odds = (seg >= SEGMENTS - QUIET_SEGMENTS) ? 0 : pick_idle_odds();
            case ($urandom_range(0, 2))
                0: insert_pct = 75;
                1: insert_pct = 25;
                default: insert_pct = 50;
            endcase
            if (seg == SEGMENTS / 2) wait_drained();
            for (n = 0; n < SEG_LEN; n++) begin
                if ($urandom_range(0, 99) < insert_pct)
                    send_item(slri_pkg::OP_INSERT, pick_value(1'b0));
                else
                    send_item(slri_pkg::OP_REMOVE, pick_value(1'b1));
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Drove %0d inserts and %0d removes, %0d results compared", n_inserts,
                 n_removes, checked);
        $display("Covered empty, full, duplicate, missing and extreme-value transactions");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
